### hw/rtl/oe_pkg.sv
// shared opcodes, status codes and precedence table for the expression evaluator
package oe_pkg;

  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_SUB  = 3'd1;
  localparam logic [2:0] OPC_MUL  = 3'd2;
  localparam logic [2:0] OPC_DIV  = 3'd3;
  localparam logic [2:0] OPC_LPAR = 3'd4;
  localparam logic [2:0] OPC_RPAR = 3'd5;
  localparam logic [2:0] OPC_END  = 3'd6;
  localparam logic [2:0] OPC_NONE = 3'd7;

  localparam logic [1:0] REL_LT  = 2'd0;
  localparam logic [1:0] REL_GT  = 2'd1;
  localparam logic [1:0] REL_EQ  = 2'd2;
  localparam logic [1:0] REL_BAD = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_OPERAND  = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [31:0] DIGIT_BASE = 32'd48;

  function automatic logic [2:0] op_code(input logic [7:0] ch);
    logic [2:0] c;
    unique case (ch)
      8'h2b:   c = OPC_ADD;
      8'h2d:   c = OPC_SUB;
      8'h2a:   c = OPC_MUL;
      8'h2f:   c = OPC_DIV;
      8'h28:   c = OPC_LPAR;
      8'h29:   c = OPC_RPAR;
      8'h23:   c = OPC_END;
      default: c = OPC_NONE;
    endcase
    return c;
  endfunction

  // relation of stack top to incoming operator
  function automatic logic [1:0] prec(input logic [2:0] top, input logic [2:0] code);
    logic [1:0] r;
    unique case (top)
      OPC_ADD, OPC_SUB:
        r = (code == OPC_MUL || code == OPC_DIV || code == OPC_LPAR) ? REL_LT : REL_GT;
      OPC_MUL, OPC_DIV:
        r = (code == OPC_LPAR) ? REL_LT : REL_GT;
      OPC_LPAR:
        r = (code == OPC_RPAR) ? REL_EQ : ((code == OPC_END) ? REL_BAD : REL_LT);
      OPC_RPAR:
        r = (code == OPC_LPAR) ? REL_BAD : REL_GT;
      OPC_END:
        r = (code == OPC_RPAR) ? REL_BAD : ((code == OPC_END) ? REL_EQ : REL_LT);
      default:
        r = REL_BAD;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/oe_stack_mem.sv
// single-port-write, registered-read stack memory
module oe_stack_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/oe_divider.sv
// iterative signed divider, truncating, one quotient bit per cycle
module oe_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] mb;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem, q[31]};
  assign fits     = rem_sh >= {1'b0, mb};
  assign quotient = neg ? 32'd0 - q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[31] ^ divisor[31];
        rem  <= '0;
        q    <= dividend[31] ? 32'd0 - dividend : dividend;
        mb   <= divisor[31] ? 32'd0 - divisor : divisor;
      end else if (busy) begin
        rem <= fits ? 32'(rem_sh - {1'b0, mb}) : rem_sh[31:0];
        q   <= {q[30:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/operator_precedence_evaluator_core.sv
// Infix expression evaluator, one character per word, result on '#'.
// Each character is taken in and decoded; each operator adds a precedence lookup
// plus, per reduction, an operand memory read, the compute and an operator memory
// read of the new top. A division reduction also waits on the bit-serial divider.
// Both stacks live in registered-read memories; stack tops are kept in registers.
module operator_precedence_evaluator_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_in,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] value,
  output logic [2:0]  status,
  output logic        out_valid,
  input  logic        out_ready
);
  import oe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_READA  = 3'd3;
  localparam logic [2:0] S_DIVW   = 3'd4;
  localparam logic [2:0] S_POPR   = 3'd5;

  logic [2:0]  state;
  logic [7:0]  ch;
  logic [2:0]  code;
  logic        discard;
  logic [CW-1:0] opc;
  logic [2:0]  optop;
  logic [CW-1:0] ndc;
  logic [31:0] ntop;
  logic        pop_to_eval;

  logic          op_we;
  logic [AW-1:0] op_waddr;
  logic [2:0]    op_rdata;
  logic          nd_we;
  logic [AW-1:0] nd_waddr;
  logic [31:0]   nd_wdata;
  logic [31:0]   nd_rdata;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  logic        out_busy;
  logic [1:0]  rel;
  logic        at_end;
  logic [31:0] red_val;

  assign in_ready = (state == S_IDLE);
  assign out_busy = out_valid && !out_ready;
  assign code     = op_code(ch);
  assign at_end   = (code == OPC_END);
  assign rel      = prec(optop, code);

  always_comb begin
    unique case (optop)
      OPC_ADD: red_val = nd_rdata + ntop;
      OPC_SUB: red_val = nd_rdata - ntop;
      default: red_val = nd_rdata * ntop;
    endcase
  end

  assign div_start = (state == S_READA) && (optop == OPC_DIV);

  oe_stack_mem #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_mem (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata (code),
    .raddr (AW'(opc - CW'(2))),
    .rdata (op_rdata)
  );

  oe_stack_mem #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_nd_mem (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (AW'(ndc - CW'(2))),
    .rdata (nd_rdata)
  );

  oe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nd_rdata),
    .divisor  (ntop),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    op_we    = (state == S_EVAL) && !out_busy && (rel == REL_LT) &&
               (opc < CW'(STACK_DEPTH));
    op_waddr = opc[AW-1:0];
    nd_we    = 1'b0;
    nd_waddr = ndc[AW-1:0];
    nd_wdata = {24'd0, ch} - DIGIT_BASE;
    if (state == S_DECODE) begin
      nd_we = !out_busy && !discard && ch != CH_SPACE && ch != CH_NEWLINE &&
              code == OPC_NONE && ndc < CW'(STACK_DEPTH);
    end else if (state == S_READA && optop != OPC_DIV) begin
      nd_we    = 1'b1;
      nd_waddr = AW'(ndc - CW'(2));
      nd_wdata = red_val;
    end else if (state == S_DIVW && div_done) begin
      nd_we    = 1'b1;
      nd_waddr = AW'(ndc - CW'(2));
      nd_wdata = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      discard     <= 1'b0;
      opc         <= CW'(1);
      optop       <= OPC_END;
      ndc         <= '0;
      out_valid   <= 1'b0;
      pop_to_eval <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch    <= char_in;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!out_busy) begin
            state <= S_IDLE;
            if (discard) begin
              if (at_end) begin
                discard <= 1'b0;
              end
            end else if (ch == CH_SPACE || ch == CH_NEWLINE) begin
              state <= S_IDLE;
            end else if (code == OPC_NONE) begin
              if (ndc >= CW'(STACK_DEPTH)) begin
                out_valid <= 1'b1;
                value     <= '0;
                status    <= ST_OVERFLOW;
                opc       <= CW'(1);
                optop     <= OPC_END;
                ndc       <= '0;
                discard   <= 1'b1;
              end else begin
                ntop <= nd_wdata;
                ndc  <= ndc + CW'(1);
              end
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (!out_busy) begin
            state <= S_IDLE;
            value <= '0;
            priority if (rel == REL_LT) begin
              if (opc >= CW'(STACK_DEPTH)) begin
                out_valid <= 1'b1;
                status    <= ST_OVERFLOW;
                opc       <= CW'(1);
                optop     <= OPC_END;
                ndc       <= '0;
                discard   <= !at_end;
              end else begin
                opc   <= opc + CW'(1);
                optop <= code;
              end
            end else if (rel == REL_GT) begin
              if (ndc < CW'(2) || optop > OPC_DIV ||
                  (optop == OPC_DIV && ntop == 32'd0)) begin
                out_valid <= 1'b1;
                status    <= (ndc < CW'(2)) ? ST_OPERAND :
                             ((optop > OPC_DIV) ? ST_MISMATCH : ST_DIVZERO);
                opc       <= CW'(1);
                optop     <= OPC_END;
                ndc       <= '0;
                discard   <= !at_end;
              end else begin
                state <= S_READA;
              end
            end else if (rel == REL_EQ) begin
              if (at_end) begin
                out_valid <= 1'b1;
                opc       <= CW'(1);
                optop     <= OPC_END;
                ndc       <= '0;
                if (ndc == '0) begin
                  status <= ST_OPERAND;
                end else begin
                  status <= ST_OK;
                  value  <= ntop;
                end
              end else if (opc > CW'(1)) begin
                opc <= opc - CW'(1);
                if (opc == CW'(2)) begin
                  optop <= OPC_END;
                end else begin
                  pop_to_eval <= 1'b0;
                  state       <= S_POPR;
                end
              end
            end else begin
              out_valid <= 1'b1;
              status    <= ST_MISMATCH;
              opc       <= CW'(1);
              optop     <= OPC_END;
              ndc       <= '0;
              discard   <= !at_end;
            end
          end
        end
        S_READA, S_DIVW: begin
          if (state == S_READA && optop == OPC_DIV) begin
            state <= S_DIVW;
          end else if (state == S_READA || div_done) begin
            ntop <= nd_wdata;
            ndc  <= ndc - CW'(1);
            opc  <= opc - CW'(1);
            if (opc == CW'(2)) begin
              optop <= OPC_END;
              state <= S_EVAL;
            end else begin
              pop_to_eval <= 1'b1;
              state       <= S_POPR;
            end
          end
        end
        S_POPR: begin
          optop <= op_rdata;
          state <= pop_to_eval ? S_EVAL : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the end marker is never popped
  a_opc_nonzero: assert property (@(posedge clk) disable iff (rst) opc != '0)
    else $error("operator stack count reached zero");
  // an error word always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 32'd0)
    else $error("error word with nonzero value");
  // divider only runs while a division reduction is pending
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished outside division wait");
  // counts stay within the stack depth
  a_ndc_range: assert property (@(posedge clk) disable iff (rst)
    ndc <= CW'(STACK_DEPTH) && opc <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
`endif

endmodule
